// ===== design/dtls_record_handshake_classifier_top_macros.svh =====
// Assertion macros shared by the DTLS record classifier
`ifndef DTLS_RECORD_HANDSHAKE_CLASSIFIER_TOP_MACROS_SVH
`define DTLS_RECORD_HANDSHAKE_CLASSIFIER_TOP_MACROS_SVH

// Check that a condition implies a consequence at the same edge
`define DTLSRC_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check that a condition implies a consequence at the next edge
`define DTLSRC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/dtlsrc_pkg.sv =====
// Types, constants and codes of the DTLS record classifier
`timescale 1ns / 1ps
package dtlsrc_pkg;

  localparam int HDR_LEN     = 13;
  localparam int PAY_KEEP    = 12;
  localparam int STORE_LEN   = HDR_LEN + PAY_KEEP;
  localparam int STORE_IDX_W = $clog2(STORE_LEN);
  localparam int CNT_W       = 17;
  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  // Request kinds on the input channel
  localparam logic OP_BYTE  = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

  // Content types
  localparam logic [7:0] CT_NONE  = 8'd0;
  localparam logic [7:0] CT_CCS   = 8'd20;
  localparam logic [7:0] CT_ALERT = 8'd21;
  localparam logic [7:0] CT_HS    = 8'd22;
  localparam logic [7:0] CT_APP   = 8'd23;

  // Handshake message types
  localparam logic [7:0] MT_CHELLO    = 8'd1;
  localparam logic [7:0] MT_SHELLO    = 8'd2;
  localparam logic [7:0] MT_HVR       = 8'd3;
  localparam logic [7:0] MT_CERT      = 8'd11;
  localparam logic [7:0] MT_SKX       = 8'd12;
  localparam logic [7:0] MT_CERTREQ   = 8'd13;
  localparam logic [7:0] MT_HELLODONE = 8'd14;
  localparam logic [7:0] MT_CERTVER   = 8'd15;
  localparam logic [7:0] MT_CKX       = 8'd16;
  localparam logic [7:0] MT_FINISHED  = 8'd20;
  localparam logic [7:0] MT_OPAQUE    = 8'hFF;

  // Session flag bit positions
  localparam int FL_COOKIE = 0;
  localparam int FL_CKE    = 1;
  localparam int FL_CCCS   = 2;
  localparam int FL_SCCS   = 3;
  localparam int FL_CFIN   = 4;
  localparam int FL_SFIN   = 5;
  localparam int FL_CREQ   = 6;
  localparam int FL_NEG    = 7;
  localparam int FL_DONE   = 8;
  localparam int FLAGS_W   = 9;

  // Status bit positions
  localparam int ST_PARSED = 0;
  localparam int ST_COOKIE = 1;
  localparam int ST_ENC    = 2;
  localparam int ST_DONE   = 3;
  localparam int ST_NEG    = 4;

  typedef enum logic [3:0] {
    REQ_NOTSET, REQ_HELLO, REQ_HELLO_COOKIE, REQ_KEYEXCH, REQ_CERTVERIFY,
    REQ_CERT, REQ_FINISHED, REQ_CCS, REQ_ALERT, REQ_APPDATA
  } req_code_t;

  typedef enum logic [3:0] {
    RSP_NOTSET, RSP_HVR, RSP_SHELLO, RSP_CERT, RSP_SKX, RSP_CERTREQ,
    RSP_HELLODONE, RSP_FINISHED, RSP_CCS, RSP_ALERT, RSP_APPDATA
  } rsp_code_t;

  // Captured record handed from the capture stage to the classifier
  typedef struct packed {
    logic                          valid;
    logic [CNT_W-1:0]              len;
    logic [STORE_LEN-1:0][7:0]     bytes;
  } rec_t;

  // One classification result
  typedef struct packed {
    logic [7:0]  alert_severity;
    logic [23:0] fragment_value;
    logic [15:0] length_value;
    logic [47:0] sequence_value;
    logic [15:0] epoch_value;
    logic [4:0]  status_flags;
    logic [7:0]  message_kind;
    logic [7:0]  record_type;
    logic [3:0]  response_code;
    logic [3:0]  request_code;
  } res_t;

  localparam int OUT_DATA_W = ($bits(res_t) + 7) / 8 * 8;

endpackage

// ===== design/dtlsrc_capture.sv =====
// Byte counter, header and payload capture, and the closed-record stage
`timescale 1ns / 1ps
module dtlsrc_capture (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_fire,
  input  logic                in_op,
  input  logic [7:0]          in_byte,
  input  logic                in_last,
  input  logic                adv,
  output dtlsrc_pkg::rec_t    rec
);

  logic [dtlsrc_pkg::CNT_W-1:0]              count_r, count_nxt, count_inc;
  logic [dtlsrc_pkg::CNT_W-1:0]              len_r, len_nxt;
  logic                                      close_r, close_nxt;
  logic [dtlsrc_pkg::STORE_LEN-1:0][7:0]     store_r;
  logic                                      byte_fire;

  assign byte_fire = in_fire && (in_op == dtlsrc_pkg::OP_BYTE);
  assign count_inc = (count_r == dtlsrc_pkg::CNT_MAX) ? count_r
                                                      : count_r + 1'b1;

  // Advance the count, snapshot the length, mark the record closed and clear the mark once it advances
  always_comb begin
    count_nxt = count_r;
    len_nxt   = len_r;
    close_nxt = close_r && !adv;
    if (byte_fire) begin
      if (in_last) begin
        count_nxt = '0;
        len_nxt   = count_inc;
        close_nxt = 1'b1;
      end else begin
        count_nxt = count_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      close_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      close_r <= close_nxt;
    end
  end

  // Keep the length with the closed record
  always_ff @(posedge clk) begin
    len_r <= len_nxt;
  end

  // Store header and leading payload bytes; later bytes are only counted
  always_ff @(posedge clk) begin
    if (byte_fire && (count_r < dtlsrc_pkg::CNT_W'(dtlsrc_pkg::STORE_LEN))) begin
      store_r[count_r[dtlsrc_pkg::STORE_IDX_W-1:0]] <= in_byte;
    end
  end

  assign rec.valid = close_r;
  assign rec.len   = len_r;
  assign rec.bytes = store_r;

endmodule

// ===== design/dtlsrc_classify.sv =====
// Record classification and the session progress flags
`timescale 1ns / 1ps
module dtlsrc_classify (
  input  logic                clk,
  input  logic                rst_n,
  input  dtlsrc_pkg::rec_t    rec,
  input  logic                adv,
  input  logic                clear,
  output dtlsrc_pkg::res_t    res
);

  logic [dtlsrc_pkg::FLAGS_W-1:0] flags_r, flags_nxt, flags_upd;
  logic [7:0]  ct, mt, sev;
  logic [15:0] epoch, rlen;
  logic [47:0] seq;
  logic [23:0] frag;
  logic        bad, enc, frag_match;
  logic [3:0]  req, rsp;
  logic [4:0]  status;

  // Pull the header fields out of the stored bytes
  always_comb begin
    ct    = rec.bytes[0];
    epoch = {rec.bytes[3], rec.bytes[4]};
    seq   = {rec.bytes[5], rec.bytes[6], rec.bytes[7], rec.bytes[8], rec.bytes[9],
             rec.bytes[10]};
    rlen  = {rec.bytes[11], rec.bytes[12]};
    frag  = {rec.bytes[22], rec.bytes[23], rec.bytes[24]};
    bad   = (rec.len < dtlsrc_pkg::CNT_W'(dtlsrc_pkg::HDR_LEN)) ||
            (ct == dtlsrc_pkg::CT_NONE) ||
            (rec.len < (dtlsrc_pkg::CNT_W'(dtlsrc_pkg::HDR_LEN) + {1'b0, rlen}));
    frag_match = ({9'd0, rlen} == ({1'b0, frag} + 25'(dtlsrc_pkg::PAY_KEEP)));
  end

  // Decide plaintext and message kind per content type
  always_comb begin
    mt  = 8'd0;
    enc = (epoch != 16'd0);
    case (ct)
      dtlsrc_pkg::CT_HS: begin
        if (rlen < 16'(dtlsrc_pkg::PAY_KEEP)) begin
          mt = dtlsrc_pkg::MT_OPAQUE;
        end else if (frag_match) begin
          mt = rec.bytes[dtlsrc_pkg::HDR_LEN];
        end else begin
          mt  = dtlsrc_pkg::MT_OPAQUE;
          enc = 1'b1;
        end
      end
      dtlsrc_pkg::CT_CCS: begin
        if (rlen == 16'd1) begin
          mt  = rec.bytes[dtlsrc_pkg::HDR_LEN];
          enc = 1'b0;
        end else begin
          mt  = dtlsrc_pkg::MT_OPAQUE;
          enc = 1'b1;
        end
      end
      dtlsrc_pkg::CT_ALERT: begin
        if ((rlen == 16'd2) && !enc) begin
          mt = rec.bytes[dtlsrc_pkg::HDR_LEN+1];
        end else begin
          mt  = dtlsrc_pkg::MT_OPAQUE;
          enc = 1'b1;
        end
      end
      dtlsrc_pkg::CT_APP: begin
        mt  = dtlsrc_pkg::MT_OPAQUE;
        enc = 1'b1;
      end
      default: begin
        mt = 8'd0;
      end
    endcase
  end

  // Classify against the flags as they stood before this record
  always_comb begin
    req = dtlsrc_pkg::REQ_NOTSET;
    rsp = dtlsrc_pkg::RSP_NOTSET;
    case (ct)
      dtlsrc_pkg::CT_HS: begin
        case (mt)
          dtlsrc_pkg::MT_CHELLO:
            req = flags_r[dtlsrc_pkg::FL_COOKIE] ? dtlsrc_pkg::REQ_HELLO_COOKIE
                                                 : dtlsrc_pkg::REQ_HELLO;
          dtlsrc_pkg::MT_CKX:     req = dtlsrc_pkg::REQ_KEYEXCH;
          dtlsrc_pkg::MT_CERTVER: req = dtlsrc_pkg::REQ_CERTVERIFY;
          dtlsrc_pkg::MT_CERT: begin
            if (flags_r[dtlsrc_pkg::FL_CREQ]) req = dtlsrc_pkg::REQ_CERT;
            rsp = dtlsrc_pkg::RSP_CERT;
          end
          dtlsrc_pkg::MT_FINISHED: begin
            if (flags_r[dtlsrc_pkg::FL_CCCS] && !flags_r[dtlsrc_pkg::FL_CFIN])
              req = dtlsrc_pkg::REQ_FINISHED;
            if (flags_r[dtlsrc_pkg::FL_SCCS] && !flags_r[dtlsrc_pkg::FL_SFIN])
              rsp = dtlsrc_pkg::RSP_FINISHED;
          end
          dtlsrc_pkg::MT_HVR:       rsp = dtlsrc_pkg::RSP_HVR;
          dtlsrc_pkg::MT_SHELLO:    rsp = dtlsrc_pkg::RSP_SHELLO;
          dtlsrc_pkg::MT_SKX:       rsp = dtlsrc_pkg::RSP_SKX;
          dtlsrc_pkg::MT_CERTREQ:   rsp = dtlsrc_pkg::RSP_CERTREQ;
          dtlsrc_pkg::MT_HELLODONE: rsp = dtlsrc_pkg::RSP_HELLODONE;
          default: begin
            req = dtlsrc_pkg::REQ_NOTSET;
          end
        endcase
      end
      dtlsrc_pkg::CT_CCS: begin
        if (flags_r[dtlsrc_pkg::FL_CKE] && !flags_r[dtlsrc_pkg::FL_CCCS])
          req = dtlsrc_pkg::REQ_CCS;
        if (flags_r[dtlsrc_pkg::FL_CFIN] && !flags_r[dtlsrc_pkg::FL_SCCS])
          rsp = dtlsrc_pkg::RSP_CCS;
      end
      dtlsrc_pkg::CT_ALERT: begin
        req = dtlsrc_pkg::REQ_ALERT;
        rsp = dtlsrc_pkg::RSP_ALERT;
      end
      dtlsrc_pkg::CT_APP: begin
        req = dtlsrc_pkg::REQ_APPDATA;
        rsp = dtlsrc_pkg::RSP_APPDATA;
      end
      default: begin
        req = dtlsrc_pkg::REQ_NOTSET;
      end
    endcase
  end

  // Advance the handshake progress flags
  always_comb begin
    flags_upd = flags_r;
    if (ct == dtlsrc_pkg::CT_HS) begin
      case (mt)
        dtlsrc_pkg::MT_HVR:     flags_upd[dtlsrc_pkg::FL_COOKIE] = 1'b1;
        dtlsrc_pkg::MT_SHELLO:  flags_upd[dtlsrc_pkg::FL_NEG]    = 1'b1;
        dtlsrc_pkg::MT_CERTREQ: flags_upd[dtlsrc_pkg::FL_CREQ]   = 1'b1;
        dtlsrc_pkg::MT_CKX:     flags_upd[dtlsrc_pkg::FL_CKE]    = 1'b1;
        dtlsrc_pkg::MT_FINISHED: begin
          if (req == dtlsrc_pkg::REQ_FINISHED)
            flags_upd[dtlsrc_pkg::FL_CFIN] = 1'b1;
          else if (rsp == dtlsrc_pkg::RSP_FINISHED)
            flags_upd[dtlsrc_pkg::FL_SFIN] = 1'b1;
          if (flags_upd[dtlsrc_pkg::FL_CFIN] && flags_upd[dtlsrc_pkg::FL_SFIN])
            flags_upd[dtlsrc_pkg::FL_DONE] = 1'b1;
        end
        default: begin
          flags_upd = flags_r;
        end
      endcase
    end else if (ct == dtlsrc_pkg::CT_CCS) begin
      if (req == dtlsrc_pkg::REQ_CCS)
        flags_upd[dtlsrc_pkg::FL_CCCS] = 1'b1;
      else if (rsp == dtlsrc_pkg::RSP_CCS)
        flags_upd[dtlsrc_pkg::FL_SCCS] = 1'b1;
    end
  end

  // Clear request wins over an update in the same cycle
  always_comb begin
    flags_nxt = flags_r;
    if (clear) flags_nxt = '0;
    else if (adv && !bad) flags_nxt = flags_upd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flags_r <= '0;
    end else begin
      flags_r <= flags_nxt;
    end
  end

  // Build the status word and the gated payload fields
  always_comb begin
    status = '0;
    status[dtlsrc_pkg::ST_PARSED] = 1'b1;
    status[dtlsrc_pkg::ST_COOKIE] = (ct == dtlsrc_pkg::CT_HS) &&
                                    (mt == dtlsrc_pkg::MT_CHELLO) &&
                                    flags_upd[dtlsrc_pkg::FL_COOKIE];
    status[dtlsrc_pkg::ST_ENC]    = enc;
    status[dtlsrc_pkg::ST_DONE]   = flags_upd[dtlsrc_pkg::FL_DONE];
    status[dtlsrc_pkg::ST_NEG]    = flags_upd[dtlsrc_pkg::FL_NEG];
    sev = ((ct == dtlsrc_pkg::CT_ALERT) && (rlen >= 16'd2) && !enc)
          ? rec.bytes[dtlsrc_pkg::HDR_LEN] : 8'd0;
  end

  // Drive the result, all zero for a short or truncated record or one of content type zero
  always_comb begin
    res = '0;
    if (!bad) begin
      res.request_code   = req;
      res.response_code  = rsp;
      res.record_type    = ct;
      res.message_kind   = mt;
      res.status_flags   = status;
      res.epoch_value    = epoch;
      res.sequence_value = seq;
      res.length_value   = rlen;
      res.fragment_value = ((ct == dtlsrc_pkg::CT_HS) &&
                            (rlen >= 16'(dtlsrc_pkg::PAY_KEEP)) && !enc) ? frag : 24'd0;
      res.alert_severity = sev;
    end
  end

endmodule

// ===== design/dtls_record_handshake_classifier_top.sv =====
// Top level of the DTLS record classifier: capture, classify, result register
// The block takes one datagram byte per cycle while in_tready is high. The byte
// flagged by in_tlast closes the record in the capture register; the output
// register then takes the classification, computed from the stored 13-byte
// header and first 12 payload bytes in a single pass. A new datagram may start
// in the very next cycle while in_tready is high, so the sustained rate is one
// request per cycle. in_tready drops only while a closed record waits and the
// output register still holds an untaken result. A session-clear request
// (in_tuser high) clears the handshake flags and gives no result.
`timescale 1ns / 1ps
`include "dtls_record_handshake_classifier_top_macros.svh"
module dtls_record_handshake_classifier_top (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [7:0]   in_tdata,   // data_byte
  input  logic         in_tuser,   // op
  input  logic         in_tlast,   // last_byte
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [dtlsrc_pkg::OUT_DATA_W-1:0] out_tdata
  // out_tdata: request_code[3:0], response_code[7:4], record_type[15:8],
  // message_kind[23:16], status_flags[28:24], epoch_value[44:29],
  // sequence_value[92:45], length_value[108:93], fragment_value[132:109],
  // alert_severity[140:133], zero fill above
);

  dtlsrc_pkg::rec_t rec;
  dtlsrc_pkg::res_t res, out_r;
  logic             out_valid_r, out_valid_nxt;
  logic             in_fire, out_free, adv, clear;

  assign out_free  = !out_valid_r || out_tready;
  assign adv       = rec.valid && out_free;
  assign in_tready = !rec.valid || out_free;
  assign in_fire   = in_tvalid && in_tready;
  assign clear     = in_fire && (in_tuser == dtlsrc_pkg::OP_CLEAR);

  dtlsrc_capture u_capture (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_fire (in_fire),
    .in_op   (in_tuser),
    .in_byte (in_tdata),
    .in_last (in_tlast),
    .adv     (adv),
    .rec     (rec)
  );

  dtlsrc_classify u_classify (
    .clk   (clk),
    .rst_n (rst_n),
    .rec   (rec),
    .adv   (adv),
    .clear (clear),
    .res   (res)
  );

  // Hold the result until the downstream side takes it
  assign out_valid_nxt = adv || (out_valid_r && !out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) out_r <= res;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = dtlsrc_pkg::OUT_DATA_W'(out_r);

  // Input stalls only behind a held result
  `DTLSRC_ASSERT_SAME(a_stall_cause, !in_tready, out_tvalid && !out_tready, "stall without held result")
  // A record that did not parse carries not-set codes
  `DTLSRC_ASSERT_SAME(a_unparsed_zero, out_tvalid && !out_r.status_flags[dtlsrc_pkg::ST_PARSED], (out_r.request_code == dtlsrc_pkg::REQ_NOTSET) && (out_r.response_code == dtlsrc_pkg::RSP_NOTSET), "unparsed record with codes")
  // Application data is always reported encrypted
  `DTLSRC_ASSERT_SAME(a_app_enc, out_tvalid && (out_r.request_code == dtlsrc_pkg::REQ_APPDATA), out_r.status_flags[dtlsrc_pkg::ST_ENC], "appdata not encrypted")
  // A closed last byte with no record waiting marks the record closed in the next cycle
  `DTLSRC_ASSERT_NEXT(a_close_to_out, in_fire && !in_tuser && in_tlast && !rec.valid, rec.valid, "closed record not staged")

endmodule
